FILE: rtl/core/miller_rabin_round_assert.svh
// Assertion macros used by the controller RTL (mrr_ctrl).
`ifndef MILLER_RABIN_ROUND_ASSERT_SVH
`define MILLER_RABIN_ROUND_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define MR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked at the next rising clock edge.
`define MR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrr_pkg;
    // Commands from the controller to the datapath.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REDUCE,
        CMD_MUL_RB,
        CMD_MUL_BB,
        CMD_MUL_XX
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic n_small;
        logic n_two;
        logic n_even;
        logic a_zero;
        logic e_zero;
        logic e_lsb;
        logic t_zero;
        logic x_one;
        logic x_m1;
        logic y_one;
    } t_status;
endpackage
`default_nettype wire

FILE: rtl/core/mrr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mrr_datapath #(
    parameter int NUM_WIDTH = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [NUM_WIDTH-1:0] i_number,
    input  wire logic [NUM_WIDTH-1:0] i_base,
    input  wire mrr_pkg::t_cmd        i_cmd,
    output mrr_pkg::t_status          o_status
);
    import mrr_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    logic [W-1:0] r_n, r_a, r_r, r_b, r_e, r_x, r_y;
    logic [CW-1:0] r_t;
    // Shared shift-and-add modular multiplier (also used for the base reduction).
    logic [W-1:0] r_mx, r_my, r_acc;
    logic [CW-1:0] r_bit;
    logic r_busy;
    t_op r_op;

    logic [W:0] dbl, dsub, sum, ssub;
    logic [W-1:0] acc2, acc3;
    always_comb begin
        dbl  = {r_acc, 1'b0};
        dsub = dbl - {1'b0, r_n};
        acc2 = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
        sum  = {1'b0, acc2} + {1'b0, r_mx};
        ssub = sum - {1'b0, r_n};
        acc3 = r_my[r_bit] ? (ssub[W] ? sum[W-1:0] : ssub[W-1:0]) : acc2;
    end

    // The base is reduced as base * 1 mod n; the operand must be below n for
    // the add step, so bit-serial over the base instead: acc = 2acc + bit.
    logic [W:0] rdbl, rsub;
    logic [W-1:0] racc;
    always_comb begin
        rdbl = {r_acc, r_my[r_bit]};
        rsub = rdbl - {1'b0, r_n};
        racc = rsub[W] ? rdbl[W-1:0] : rsub[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= CMD_NONE;
        end else if (i_cmd.start) begin
            r_busy <= (i_cmd.op != CMD_LOAD) && (i_cmd.op != CMD_NONE);
            r_op   <= i_cmd.op;
            r_acc  <= '0;
            r_bit  <= CW'(W - 1);
            unique case (i_cmd.op)
                CMD_LOAD: begin
                    r_n <= i_number;
                    r_a <= i_base;
                    r_e <= i_number - ONE;
                    r_t <= '0;
                end
                CMD_REDUCE: begin r_mx <= r_n; r_my <= r_a; end
                CMD_MUL_RB: begin r_mx <= r_r; r_my <= r_b; end
                CMD_MUL_BB: begin r_mx <= r_b; r_my <= r_b; end
                CMD_MUL_XX: begin r_mx <= r_x; r_my <= r_x; end
                default: ;
            endcase
        end else if (r_busy) begin
            r_acc <= (r_op == CMD_REDUCE) ? racc : acc3;
            if (r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end else begin
                r_busy <= 1'b0;
                unique case (r_op)
                    CMD_REDUCE: begin
                        r_b <= racc;
                        r_r <= ONE;
                        // The exponent was already split into u * 2^t after the load.
                    end
                    CMD_MUL_RB: r_r <= acc3;
                    CMD_MUL_BB: begin r_b <= acc3; r_e <= r_e >> 1; end
                    CMD_MUL_XX: begin r_y <= acc3; r_x <= acc3; end
                    default: ;
                endcase
            end
        end else if (i_cmd.op == CMD_NONE && r_op == CMD_LOAD && !r_e[0] && r_e != '0) begin
            // Split n-1 into u * 2^t after the load, shifting one trailing zero out of the exponent per step.
            r_e <= r_e >> 1;
            r_t <= r_t + 1'b1;
        end else if (r_op == CMD_MUL_XX && !r_busy && i_cmd.op == CMD_NONE) begin
            r_op <= CMD_NONE;
            r_t  <= r_t - 1'b1;
        end else if (r_op == CMD_MUL_BB && r_e == '0) begin
            r_x  <= r_r;
            r_y  <= '0;
            r_op <= CMD_NONE;
        end
    end

    assign o_status.busy    = r_busy || (r_op == CMD_LOAD && !r_e[0] && r_e != '0)
                              || (r_op == CMD_MUL_XX) || (r_op == CMD_MUL_BB && r_e == '0);
    assign o_status.n_small = (r_n < W'(2));
    assign o_status.n_two   = (r_n == W'(2));
    assign o_status.n_even  = !r_n[0];
    assign o_status.a_zero  = (r_b == '0);
    assign o_status.e_zero  = (r_e == '0);
    assign o_status.e_lsb   = r_e[0];
    assign o_status.t_zero  = (r_t == '0);
    assign o_status.x_one   = (r_x == ONE);
    assign o_status.x_m1    = (r_x == r_n - ONE);
    assign o_status.y_one   = (r_y == ONE);
endmodule
`default_nettype wire

FILE: rtl/core/mrr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mrr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_verdict,
    input  wire mrr_pkg::t_status i_status,
    output mrr_pkg::t_cmd         o_cmd
);
    import mrr_pkg::*;
    `include "miller_rabin_round_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_SPLIT, S_RED, S_PCHK, S_PMUL, S_PSQ,
        S_SQ, S_SQCHK, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid, r_verdict, r_prev_x_ok, r_wait;
    logic   r_start;
    t_op    r_op;
    logic   accept;

    assign o_ready   = (r_state == S_IDLE) && !r_valid;
    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;
    assign accept    = i_valid && o_ready;
    // The load goes out in the accepting cycle, so the datapath captures the
    // payload at the same edge that takes the item.
    assign o_cmd.op    = accept ? CMD_LOAD : r_op;
    assign o_cmd.start = r_start || accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_start <= 1'b0;
            r_op    <= CMD_NONE;
            r_wait  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            r_op    <= CMD_NONE;
            if (r_valid && i_ready) r_valid <= 1'b0;
            if (r_wait) begin
                r_wait <= 1'b0;
            end else begin
                unique case (r_state)
                    S_IDLE: if (accept) begin
                        r_state <= S_SPLIT;
                    end
                    S_SPLIT: if (i_status.n_small || (i_status.n_even && !i_status.n_two)) begin
                        r_verdict <= 1'b1; r_state <= S_OUT;
                    end else if (i_status.n_two) begin
                        r_verdict <= 1'b0; r_state <= S_OUT;
                    end else if (!i_status.busy) begin
                        r_start <= 1'b1; r_op <= CMD_REDUCE; r_wait <= 1'b1;
                        r_state <= S_RED;
                    end
                    S_RED: if (!i_status.busy) begin
                        if (i_status.a_zero) begin
                            r_verdict <= 1'b0; r_state <= S_OUT;
                        end else r_state <= S_PCHK;
                    end
                    S_PCHK: if (!i_status.busy) begin
                        if (i_status.e_zero) r_state <= S_SQ;
                        else if (i_status.e_lsb) begin
                            r_start <= 1'b1; r_op <= CMD_MUL_RB; r_wait <= 1'b1;
                            r_state <= S_PMUL;
                        end else begin
                            r_start <= 1'b1; r_op <= CMD_MUL_BB; r_wait <= 1'b1;
                            r_state <= S_PSQ;
                        end
                    end
                    S_PMUL: if (!i_status.busy) begin
                        r_start <= 1'b1; r_op <= CMD_MUL_BB; r_wait <= 1'b1;
                        r_state <= S_PSQ;
                    end
                    S_PSQ: if (!i_status.busy) r_state <= S_PCHK;
                    S_SQ: if (!i_status.busy) begin
                        if (i_status.t_zero) begin
                            r_verdict <= !i_status.y_one; r_state <= S_OUT;
                        end else begin
                            r_prev_x_ok <= i_status.x_one || i_status.x_m1;
                            r_start <= 1'b1; r_op <= CMD_MUL_XX; r_wait <= 1'b1;
                            r_state <= S_SQCHK;
                        end
                    end
                    S_SQCHK: if (!i_status.busy) begin
                        if (i_status.y_one && !r_prev_x_ok) begin
                            r_verdict <= 1'b1; r_state <= S_OUT;
                        end else r_state <= S_SQ;
                    end
                    S_OUT: if (!r_valid) begin
                        r_valid <= 1'b1; r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    `MR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_verdict), "result dropped while stalled")
    `MR_ASSERT_IMPL(a_nostart, i_clk, i_rst_n, r_start, r_state != S_IDLE, "command issued from idle")
    `MR_ASSERT_IMPL(a_accept, i_clk, i_rst_n, o_ready, !r_valid, "item taken while result pending")
endmodule
`default_nettype wire

FILE: rtl/core/miller_rabin_round.sv
`timescale 1ns / 1ps
`default_nettype none
// One Miller-Rabin round per item: verdict 1 means number is composite (or below 2, or even
// above 2), 0 means probable prime for the given base. One item is in work at a time. Every
// modular product runs bit-serially on one shared shift-and-add unit, after a command
// handshake. The count of sequential products sets the item time: one for the base
// reduction, one squaring per exponent bit, one multiply per set exponent bit and one per
// doubling, at most about 2 * NUM_WIDTH in all; trivial numbers need no product at all.
module miller_rabin_round #(
    parameter int NUM_WIDTH = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [62:0] i_number,
    input  wire logic [62:0] i_base,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_verdict
);
    import mrr_pkg::*;

    t_cmd    cmd;
    t_status status;

    mrr_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_number(i_number[NUM_WIDTH-1:0]), .i_base(i_base[NUM_WIDTH-1:0]),
        .i_cmd(cmd), .o_status(status)
    );

    mrr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_verdict(o_verdict),
        .i_status(status), .o_cmd(cmd)
    );
endmodule
`default_nettype wire
